@@ design/tccw_pkg.sv @@
`timescale 1ns / 1ps
package tccw_pkg;

  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  localparam int OP_W   = 1;
  localparam int CHAR_W = 8;
  localparam int IDX_W  = 11;
  localparam int CUR_W  = 11;
  localparam int CELL_W = 16;

  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;
  localparam logic [7:0]        ATTR_BYTE  = 8'h07;

  localparam logic [CHAR_W-1:0] CH_CR = 8'd13;
  localparam logic [CHAR_W-1:0] CH_LF = 8'd10;
  localparam logic [CHAR_W-1:0] CH_BS = 8'd8;

  localparam logic [OP_W-1:0] OP_PUT  = 1'b0;
  localparam logic [OP_W-1:0] OP_READ = 1'b1;

  typedef enum logic {
    R_IDX,
    R_PTRCOL
  } rsel_e;

  typedef enum logic [1:0] {
    W_NONE,
    W_BLANK,
    W_COPY,
    W_PUT
  } wop_e;

  typedef enum logic [1:0] {
    P_HOLD,
    P_ZERO,
    P_INC
  } pop_e;

  typedef enum logic [1:0] {
    O_NONE,
    O_PUT,
    O_READ
  } osel_e;

  // datapath control word
  typedef struct packed {
    logic  lat;
    rsel_e rsel;
    wop_e  wop;
    pop_e  pop;
    logic  cur_ld;
    osel_e osel;
  } ctrl_t;

  // datapath status for conditional jumps
  typedef struct packed {
    logic op_rd;
    logic wrap;
    logic cpy_end;
    logic clr_end;
  } stat_t;

endpackage

@@ design/tccw_seq.sv @@
`timescale 1ns / 1ps
module tccw_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  tccw_pkg::stat_t st_i,
  output tccw_pkg::ctrl_t ctl_o,
  output logic            busy_o
);
  import tccw_pkg::*;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_DISP,
    S_PUT,
    S_PDONE,
    S_RDOUT,
    S_SCRR,
    S_SCRW,
    S_BLANK
  } step_e;

  typedef enum logic [2:0] {
    J_NONE,
    J_START,
    J_OPRD,
    J_WRAP,
    J_CPYEND,
    J_CLREND
  } cond_e;

  typedef struct packed {
    step_e nxt;
    step_e alt;
    cond_e cond;
    logic  busy;
    ctrl_t ctl;
  } uword_t;

  function automatic uword_t urom(step_e s);
    uword_t w;
    w = '{nxt: S_IDLE, alt: S_IDLE, cond: J_NONE, busy: 1'b1,
          ctl: '{lat: 1'b0, rsel: R_IDX, wop: W_NONE, pop: P_HOLD,
                 cur_ld: 1'b0, osel: O_NONE}};
    case (s)
      S_CLR: begin
        w.nxt = S_CLR; w.alt = S_IDLE; w.cond = J_CLREND;
        w.ctl.wop = W_BLANK; w.ctl.pop = P_INC;
      end
      S_IDLE: begin
        w.nxt = S_IDLE; w.alt = S_DISP; w.cond = J_START;
        w.busy = 1'b0; w.ctl.lat = 1'b1;
      end
      S_DISP: begin
        w.nxt = S_PUT; w.alt = S_RDOUT; w.cond = J_OPRD;
        w.ctl.rsel = R_IDX;
      end
      S_PUT: begin
        w.nxt = S_PDONE; w.alt = S_SCRR; w.cond = J_WRAP;
        w.ctl.wop = W_PUT; w.ctl.pop = P_ZERO; w.ctl.cur_ld = 1'b1;
      end
      S_PDONE: begin
        w.ctl.osel = O_PUT;
      end
      S_RDOUT: begin
        w.ctl.osel = O_READ;
      end
      S_SCRR: begin
        w.nxt = S_SCRW; w.ctl.rsel = R_PTRCOL;
      end
      S_SCRW: begin
        w.nxt = S_SCRR; w.alt = S_BLANK; w.cond = J_CPYEND;
        w.ctl.wop = W_COPY; w.ctl.pop = P_INC;
      end
      S_BLANK: begin
        w.nxt = S_BLANK; w.alt = S_PDONE; w.cond = J_CLREND;
        w.ctl.wop = W_BLANK; w.ctl.pop = P_INC;
      end
      default: ;
    endcase
    return w;
  endfunction

  step_e  upc_q, upc_d;
  uword_t uw;
  logic   take;

  always_comb begin
    uw = urom(upc_q);
    case (uw.cond)
      J_START:  take = start_i;
      J_OPRD:   take = st_i.op_rd;
      J_WRAP:   take = st_i.wrap;
      J_CPYEND: take = st_i.cpy_end;
      J_CLREND: take = st_i.clr_end;
      default:  take = 1'b0;
    endcase
    upc_d = take ? uw.alt : uw.nxt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= S_CLR;
    end else begin
      upc_q <= upc_d;
    end
  end

  assign ctl_o  = uw.ctl;
  assign busy_o = uw.busy;

endmodule

@@ design/tccw_dp.sv @@
`timescale 1ns / 1ps
module tccw_dp #(
  parameter int COLUMNS = tccw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tccw_pkg::DEF_ROWS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tccw_pkg::ctrl_t              ctl_i,
  input  logic [tccw_pkg::OP_W-1:0]    opcode_i,
  input  logic [tccw_pkg::CHAR_W-1:0]  char_code_i,
  input  logic [tccw_pkg::IDX_W-1:0]   cell_index_i,
  output tccw_pkg::stat_t              st_o,
  output logic                         done_o,
  output logic [tccw_pkg::CUR_W-1:0]   cursor_out_o,
  output logic [tccw_pkg::CELL_W-1:0]  cell_value_o,
  output logic                         scrolled_o
);
  import tccw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = AW + 1;
  localparam int CLW   = $clog2(COLUMNS);
  localparam int XW    = (AW > IDX_W) ? AW : IDX_W;

  localparam logic [CW-1:0]  CELLS_C  = CW'(CELLS);
  localparam logic [CW-1:0]  COLS_C   = CW'(COLUMNS);
  localparam logic [CW-1:0]  CLR_END  = CW'(CELLS - 1);
  localparam logic [CW-1:0]  CPY_END  = CW'(CELLS - COLUMNS - 1);
  localparam logic [AW-1:0]  LAST_ROW = AW'(CELLS - COLUMNS);
  localparam logic [CLW-1:0] COL_MAX  = CLW'(COLUMNS - 1);
  localparam logic [XW-1:0]  CELLS_X  = XW'(CELLS);

  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] rd_q;

  logic [AW-1:0]     cur_q, cur_d;
  logic [CLW-1:0]    col_q, col_d;
  logic [CW-1:0]     ptr_q, ptr_d;
  logic              scr_q, scr_d;
  logic              done_q;
  logic [OP_W-1:0]   op_q;
  logic [CHAR_W-1:0] ch_q;
  logic [IDX_W-1:0]  idx_q;

  logic [CW-1:0]     cur_x, col_x, new_cur;
  logic [CLW-1:0]    new_col;
  logic [AW-1:0]     put_addr;
  logic              put_wr;
  logic [CELL_W-1:0] put_data;
  logic              wrap;

  logic [XW-1:0]     idx_x;
  logic              idx_ok;
  logic [AW-1:0]     ra, wa;
  logic              we;
  logic [CELL_W-1:0] wd;

  always_comb begin
    cur_x    = CW'(cur_q);
    col_x    = CW'(col_q);
    new_cur  = cur_x + CW'(1);
    new_col  = (col_q == COL_MAX) ? '0 : col_q + CLW'(1);
    put_addr = cur_q;
    put_wr   = 1'b1;
    put_data = {ATTR_BYTE, ch_q};
    case (ch_q)
      CH_CR: begin
        new_cur = cur_x - col_x;
        new_col = '0;
        put_wr  = 1'b0;
      end
      CH_LF: begin
        new_cur = cur_x + COLS_C - col_x;
        new_col = '0;
        put_wr  = 1'b0;
      end
      CH_BS: begin
        put_data = BLANK_CELL;
        if (cur_q == '0) begin
          new_cur = '0;
          new_col = '0;
        end else begin
          new_cur = cur_x - CW'(1);
          new_col = (col_q == '0) ? COL_MAX : col_q - CLW'(1);
        end
        put_addr = AW'(new_cur);
      end
      default: ;
    endcase
    wrap = (new_cur >= CELLS_C);
  end

  always_comb begin
    idx_x  = XW'(idx_q);
    idx_ok = (idx_x < CELLS_X);
    case (ctl_i.rsel)
      R_PTRCOL: ra = AW'(ptr_q + COLS_C);
      default:  ra = idx_ok ? AW'(idx_x) : '0;
    endcase
    we = 1'b0;
    wa = AW'(ptr_q);
    wd = BLANK_CELL;
    case (ctl_i.wop)
      W_BLANK: we = 1'b1;
      W_COPY: begin
        we = 1'b1;
        wd = rd_q;
      end
      W_PUT: begin
        we = put_wr;
        wa = put_addr;
        wd = put_data;
      end
      default: ;
    endcase
    case (ctl_i.pop)
      P_ZERO:  ptr_d = '0;
      P_INC:   ptr_d = ptr_q + CW'(1);
      default: ptr_d = ptr_q;
    endcase
    cur_d = cur_q;
    col_d = col_q;
    scr_d = scr_q;
    if (ctl_i.cur_ld) begin
      cur_d = wrap ? LAST_ROW : AW'(new_cur);
      col_d = wrap ? '0 : new_col;
      scr_d = wrap;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q  <= '0;
      col_q  <= '0;
      ptr_q  <= '0;
      scr_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cur_q  <= cur_d;
      col_q  <= col_d;
      ptr_q  <= ptr_d;
      scr_q  <= scr_d;
      done_q <= (ctl_i.osel != O_NONE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.lat) begin
      op_q  <= opcode_i;
      ch_q  <= char_code_i;
      idx_q <= cell_index_i;
    end
    case (ctl_i.osel)
      O_PUT: begin
        cursor_out_o <= CUR_W'(cur_q);
        cell_value_o <= '0;
        scrolled_o   <= scr_q;
      end
      O_READ: begin
        cursor_out_o <= CUR_W'(cur_q);
        cell_value_o <= idx_ok ? rd_q : '0;
        scrolled_o   <= 1'b0;
      end
      default: ;
    endcase
  end

  assign st_o.op_rd   = (op_q == OP_READ);
  assign st_o.wrap    = wrap;
  assign st_o.cpy_end = (ptr_q == CPY_END);
  assign st_o.clr_end = (ptr_q == CLR_END);
  assign done_o       = done_q;

endmodule

@@ design/text_console_char_writer_unit.sv @@
`timescale 1ns / 1ps
// Text console character writer: COLUMNS x ROWS screen of 16-bit cells plus cursor.
// Command channel: an item transfers at a rising edge with start high and busy low.
//   opcode_i = 0 puts char_code_i (CR, LF, backspace or printable),
//   opcode_i = 1 reads the cell at cell_index_i (0 returned when out of range).
// Result channel: done_o is high for exactly one cycle with cursor_out_o,
//   cell_value_o and scrolled_o valid; the receiver cannot stall it.
// Steps after the accept edge (microcode program), busy high until back in S_IDLE:
//   read: S_DISP, then S_RDOUT, whose result is registered onto the outputs.
//   put:  S_DISP, S_PUT (cell write and cursor update), then S_PDONE.
//   put that scrolls: S_PUT, then S_SCRR/S_SCRW per cell for the row move (one
//   memory read and one write per cell), S_BLANK over the last row, then S_PDONE.
// The result cycle overlaps the next idle cycle, so a new item can transfer
// while done_o is high.
// Reset: cursor goes to 0 and the sequencer sweeps the screen memory to blank,
// one cell per cycle over all COLUMNS*ROWS cells, with busy high.
module text_console_char_writer_unit #(
  parameter int COLUMNS = tccw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tccw_pkg::DEF_ROWS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [tccw_pkg::OP_W-1:0]    opcode_i,
  input  logic [tccw_pkg::CHAR_W-1:0]  char_code_i,
  input  logic [tccw_pkg::IDX_W-1:0]   cell_index_i,
  output logic                         done_o,
  output logic [tccw_pkg::CUR_W-1:0]   cursor_out_o,
  output logic [tccw_pkg::CELL_W-1:0]  cell_value_o,
  output logic                         scrolled_o
);
  import tccw_pkg::*;

  ctrl_t ctl;
  stat_t st;

  tccw_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .st_i    (st),
    .ctl_o   (ctl),
    .busy_o  (busy)
  );

  tccw_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .opcode_i     (opcode_i),
    .char_code_i  (char_code_i),
    .cell_index_i (cell_index_i),
    .st_o         (st),
    .done_o       (done_o),
    .cursor_out_o (cursor_out_o),
    .cell_value_o (cell_value_o),
    .scrolled_o   (scrolled_o)
  );

endmodule

@@ design/tccw_chk.sv @@
`timescale 1ns / 1ps
module tccw_chk #(
  parameter int COLUMNS = tccw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tccw_pkg::DEF_ROWS
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start,
  input logic                         busy,
  input logic                         done_o,
  input logic [tccw_pkg::CUR_W-1:0]   cursor_out_o,
  input logic [tccw_pkg::CELL_W-1:0]  cell_value_o,
  input logic                         scrolled_o
);
  import tccw_pkg::*;

  localparam logic [CUR_W-1:0] SCR_CUR = CUR_W'((ROWS - 1) * COLUMNS);

  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy low right after a command transfer");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_scroll_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && scrolled_o) |-> (cursor_out_o == SCR_CUR))
    else $error("cursor not at last row start after scroll");

  a_read_no_scroll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (cell_value_o != '0)) |-> !scrolled_o)
    else $error("read result flagged as scrolled");

endmodule

bind text_console_char_writer_unit tccw_chk #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .done_o       (done_o),
  .cursor_out_o (cursor_out_o),
  .cell_value_o (cell_value_o),
  .scrolled_o   (scrolled_o)
);

@@ verif/tccw_checker.sv @@
`timescale 1ns / 1ps
module tccw_checker #(
  parameter int COLUMNS = tccw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tccw_pkg::DEF_ROWS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  input  logic                        busy,
  input  logic [tccw_pkg::OP_W-1:0]   opcode_i,
  input  logic [tccw_pkg::CHAR_W-1:0] char_code_i,
  input  logic [tccw_pkg::IDX_W-1:0]  cell_index_i,
  input  logic                        done_o,
  input  logic [tccw_pkg::CUR_W-1:0]  cursor_out_o,
  input  logic [tccw_pkg::CELL_W-1:0] cell_value_o,
  input  logic                        scrolled_o,
  output int                          fail_count_o,
  output int                          pending_o
);
  import tccw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;

  typedef struct packed {
    logic [CUR_W-1:0]  cursor;
    logic [CELL_W-1:0] cell_val;
    logic              scrolled;
  } console_result_t;

  logic [CELL_W-1:0] screen_model [CELLS];
  int unsigned       cursor_model;
  console_result_t   expected_results [$];
  console_result_t   head_res;
  int                mismatches;

  task automatic apply_console_item(input logic [OP_W-1:0] op,
                                    input logic [CHAR_W-1:0] ch,
                                    input logic [IDX_W-1:0] idx);
    int unsigned       cur;
    logic [CELL_W-1:0] value;
    logic              rolled;
    console_result_t   res;
    cur    = cursor_model;
    value  = '0;
    rolled = 1'b0;
    if (cur >= CELLS) cur = 0;
    if (op == OP_READ) begin
      if (idx < CELLS) value = screen_model[idx];
    end else begin
      if (ch == CH_CR) begin
        cur = cur - cur % COLUMNS;
      end else if (ch == CH_LF) begin
        cur = cur + COLUMNS - cur % COLUMNS;
      end else if (ch == CH_BS) begin
        if (cur > 0) cur--;
        screen_model[cur] = BLANK_CELL;
      end else begin
        screen_model[cur] = {ATTR_BYTE, ch};
        cur++;
      end
      // end of screen: move rows up, blank the last one
      if (cur >= CELLS) begin
        for (int i = 0; i < CELLS - COLUMNS; i++) screen_model[i] = screen_model[i + COLUMNS];
        for (int i = CELLS - COLUMNS; i < CELLS; i++) screen_model[i] = BLANK_CELL;
        cur    = CELLS - COLUMNS;
        rolled = 1'b1;
      end
      cursor_model = cur;
    end
    res.cursor   = cursor_model[CUR_W-1:0];
    res.cell_val = value;
    res.scrolled = rolled;
    expected_results.push_back(res);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CELLS; i++) screen_model[i] = BLANK_CELL;
      cursor_model = 0;
      expected_results.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (done_o === 1'b1) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with nothing expected: cursor_out %0d, cell_value %h",
                 cursor_out_o, cell_value_o);
          mismatches++;
        end else begin
          head_res = expected_results.pop_front();
          if (cursor_out_o !== head_res.cursor) begin
            $error("cursor_out: expected %0d, got %0d", head_res.cursor, cursor_out_o);
            mismatches++;
          end
          if (cell_value_o !== head_res.cell_val) begin
            $error("cell_value: expected %h, got %h", head_res.cell_val, cell_value_o);
            mismatches++;
          end
          if (scrolled_o !== head_res.scrolled) begin
            $error("scrolled: expected %0b, got %0b", head_res.scrolled, scrolled_o);
            mismatches++;
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        apply_console_item(opcode_i, char_code_i, cell_index_i);
      end
      fail_count_o <= mismatches;
      pending_o    <= expected_results.size();
    end
  end

endmodule

@@ verif/tb_text_console_char_writer_unit.sv @@
`timescale 1ns / 1ps
module tb_text_console_char_writer_unit;
  import tccw_pkg::*;

  localparam int LIMIT     = 20000;
  localparam int N_RANDOM  = 900;
  localparam int CALM_TAIL = 150;
  localparam int HOLD_AT   = 450;

  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              start        = 1'b0;
  logic [OP_W-1:0]   opcode_i     = OP_PUT;
  logic [CHAR_W-1:0] char_code_i  = '0;
  logic [IDX_W-1:0]  cell_index_i = '0;
  logic              busy;
  logic              done_o;
  logic [CUR_W-1:0]  cursor_out_o;
  logic [CELL_W-1:0] cell_value_o;
  logic              scrolled_o;
  int                fail_count;
  int                pending;
  int                stall_cycles = 0;

  always #10 clk_i = ~clk_i;

  text_console_char_writer_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .opcode_i    (opcode_i),
    .char_code_i (char_code_i),
    .cell_index_i(cell_index_i),
    .done_o      (done_o),
    .cursor_out_o(cursor_out_o),
    .cell_value_o(cell_value_o),
    .scrolled_o  (scrolled_o)
  );

  tccw_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .opcode_i    (opcode_i),
    .char_code_i (char_code_i),
    .cell_index_i(cell_index_i),
    .done_o      (done_o),
    .cursor_out_o(cursor_out_o),
    .cell_value_o(cell_value_o),
    .scrolled_o  (scrolled_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // leaves start high; the caller lowers it when a gap follows
  task automatic send_item(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                           input logic [IDX_W-1:0] idx);
    start        <= 1'b1;
    opcode_i     <= op;
    char_code_i  <= ch;
    cell_index_i <= idx;
    do @(posedge clk_i); while (busy !== 1'b0);
  endtask

  task automatic send_random_item();
    int unsigned       pick;
    logic [OP_W-1:0]   op;
    logic [CHAR_W-1:0] ch;
    logic [IDX_W-1:0]  idx;
    pick = $urandom_range(0, 99);
    op   = OP_PUT;
    ch   = CHAR_W'($urandom_range(0, 255));
    idx  = IDX_W'($urandom_range(0, 2047));
    if (pick < 25) begin
      op = OP_READ;
      // favor the bottom rows, where most writing lands
      if ($urandom_range(0, 1) == 0) idx = IDX_W'($urandom_range(1840, 1999));
    end else if (pick < 31) begin
      ch = CH_CR;
    end else if (pick < 39) begin
      ch = CH_LF;
    end else if (pick < 45) begin
      ch = CH_BS;
    end
    send_item(op, ch, idx);
  endtask

  always @(posedge clk_i) begin
    if ((start === 1'b1 && busy === 1'b0) || done_o === 1'b1) begin
      stall_cycles <= 0;
    end else if (rst_ni) begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset contents, out-of-range reads, backspace at cell zero, byte extremes
    send_item(OP_READ, 8'h00, 11'd0);
    send_item(OP_READ, 8'hFF, 11'd1999);
    send_item(OP_READ, 8'h00, 11'd2047);
    send_item(OP_READ, 8'h00, 11'd2000);
    send_item(OP_PUT, CH_BS, 11'd0);
    send_item(OP_PUT, 8'hFF, 11'd2047);
    send_item(OP_PUT, 8'h00, 11'd0);
    send_item(OP_READ, 8'h00, 11'd0);
    send_item(OP_READ, 8'h00, 11'd1);
    send_item(OP_PUT, CH_CR, 11'd0);
    send_item(OP_PUT, 8'h41, 11'd0);
    send_item(OP_READ, 8'h00, 11'd0);
    send_item(OP_PUT, CH_LF, 11'd0);
    send_item(OP_PUT, CH_BS, 11'd0);
    send_item(OP_READ, 8'h00, 11'd79);
    send_item(OP_PUT, 8'h7F, 11'd0);
    send_item(OP_PUT, CH_LF, 11'd0);
    send_item(OP_READ, 8'h00, 11'd80);

    for (int n = 0; n < N_RANDOM; n++) begin
      send_random_item();
      if (n == HOLD_AT) begin
        start <= 1'b0;
        do @(posedge clk_i); while (pending != 0);
      end else if (n < N_RANDOM - CALM_TAIL && $urandom_range(0, 99) < 30) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end
    end
    start <= 1'b0;

    do @(posedge clk_i); while (pending != 0);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/tccw_pkg.sv
design/tccw_seq.sv
design/tccw_dp.sv
design/text_console_char_writer_unit.sv
design/tccw_chk.sv
verif/tccw_checker.sv
verif/tb_text_console_char_writer_unit.sv
